@@ rtl/bti_pkg.sv @@
package bti_pkg;

  // Fixed field widths of the channels and the register
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_ZERO_DEN = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_LAST,
    ST_CHECK_LAST,
    ST_SCAN,
    ST_DIFF,
    ST_SETUP,
    ST_MUL,
    ST_OVF,
    ST_DIV,
    ST_FINAL,
    ST_DONE
  } state_t;

endpackage

@@ rtl/bti_if.sv @@
// Input item channel: write a breakpoint pair or query an x
interface bti_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [bti_pkg::IDX_W-1:0]      entry_index;
  logic signed [VALUE_WIDTH-1:0]  entry_x;
  logic signed [VALUE_WIDTH-1:0]  entry_y;
  logic signed [VALUE_WIDTH-1:0]  query_x;

  modport source (
    output valid, command, entry_index, entry_x, entry_y, query_x,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_x, entry_y, query_x,
    output ready
  );
endinterface

// Result item channel
interface bti_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_WIDTH-1:0]  result_y;
  bti_pkg::status_t               status;

  modport source (
    output valid, result_y, status,
    input  ready
  );
  modport sink (
    input  valid, result_y, status,
    output ready
  );
endinterface

@@ rtl/breakpoint_table_interpolation.sv @@
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    command, entry_index, entry_x, entry_y, query_x
// out_ch    out  valid / ready    result_y, status
// cfg       in   cfg_wr_en        cfg_wr_data (table_length)
//
// A write, or a query on an empty table, goes straight to ST_DONE; a query at or above the
// first x ends after ST_FETCH_LAST, one at or below the last x after ST_CHECK_LAST,
// and any other query scans the n pairs in use, reading one entry a cycle; then one shared
// add/subtract unit does a shift-add multiply and a restoring divide, one bit a cycle each.
// in_ch is ready only while idle, the cycle after the result is loaded; a full output
// register holds the sequencer in its last state. rst is synchronous; no table clear.
module breakpoint_table_interpolation #(
  parameter int MAX_ENTRIES = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bti_pkg::LEN_W-1:0] cfg_wr_data,
  bti_in_if.sink                    in_ch,
  bti_out_if.source                 out_ch
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (NW > bti_pkg::LEN_W) ? NW : bti_pkg::LEN_W;
  localparam int SW = $clog2(VALUE_WIDTH);

  // |a - b| of two signed values, always fits W bits unsigned
  function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    return d[W] ? W'(-d) : d[W-1:0];
  endfunction

  bti_pkg::state_t            state, state_next;
  logic [bti_pkg::LEN_W-1:0]  table_length;

  // Breakpoint table
  logic signed [W-1:0]        x_mem [MAX_ENTRIES];
  logic signed [W-1:0]        y_mem [MAX_ENTRIES];
  logic [AW-1:0]              rd_addr;
  logic signed [W-1:0]        rd_x, rd_y;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;

  logic [CW-1:0]              n_ext, n_m1, idx_ext;
  logic                       idx_ok;

  // Query datapath
  logic signed [W-1:0]        q, prev_x, prev_y, cur_x, cur_y;
  logic [AW-1:0]              cnt, last;
  logic [SW-1:0]              step;
  logic [W-1:0]               dy, dq, dx, p_hi, p_lo;
  logic                       neg_num, neg_div;
  logic                       seg_hit;
  logic signed [W-1:0]        res_y;
  bti_pkg::status_t           res_status;

  // Shared add/subtract unit
  logic [W+1:0]               alu_a, alu_b, alu_sum;
  logic                       alu_sub;
  logic [W:0]                 rem2, mul_sum;
  logic                       div_ge;
  logic [W-1:0]               sat_max, sat_min;
  logic signed [W-1:0]        final_y;

  // Output register
  logic                       in_ready, out_load, out_valid;
  logic signed [W-1:0]        out_result;
  bti_pkg::status_t           out_status;

  // Pairs in use, clamped to the table depth
  always_comb begin
    n_ext = (CW'(table_length) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(table_length);
    n_m1    = n_ext - CW'(1);
    idx_ext = CW'(in_ch.entry_index);
    idx_ok  = idx_ext < n_ext;
    wr_addr = idx_ext[AW-1:0];
  end

  assign sat_max = {1'b0, {(W-1){1'b1}}};
  assign sat_min = {1'b1, {(W-1){1'b0}}};
  assign seg_hit = (q < prev_x) && (q >= rd_x);

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      bti_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.command == bti_pkg::CMD_WRITE) begin
            wr_en      = idx_ok;
            state_next = bti_pkg::ST_DONE;
          end else if (n_ext == '0) begin
            state_next = bti_pkg::ST_DONE;
          end else begin
            state_next = bti_pkg::ST_FETCH_LAST;
          end
        end
      end
      bti_pkg::ST_FETCH_LAST: begin
        rd_addr = last;
        state_next = (q >= rd_x) ? bti_pkg::ST_DONE : bti_pkg::ST_CHECK_LAST;
      end
      bti_pkg::ST_CHECK_LAST: begin
        rd_addr = AW'(1);
        state_next = (q <= rd_x) ? bti_pkg::ST_DONE : bti_pkg::ST_SCAN;
      end
      bti_pkg::ST_SCAN: begin
        rd_addr = (cnt == last) ? cnt : cnt + AW'(1);
        if (seg_hit || cnt == last) begin
          state_next = bti_pkg::ST_DIFF;
        end
      end
      bti_pkg::ST_DIFF: begin
        state_next = bti_pkg::ST_SETUP;
      end
      bti_pkg::ST_SETUP: begin
        state_next = (dx == '0) ? bti_pkg::ST_DONE : bti_pkg::ST_MUL;
      end
      bti_pkg::ST_MUL: begin
        if (step == SW'(W - 1)) begin
          state_next = bti_pkg::ST_OVF;
        end
      end
      bti_pkg::ST_OVF: begin
        // high half of the product at or above the divisor: quotient too wide
        state_next = div_ge ? bti_pkg::ST_DONE : bti_pkg::ST_DIV;
      end
      bti_pkg::ST_DIV: begin
        if (step == SW'(W - 1)) begin
          state_next = bti_pkg::ST_FINAL;
        end
      end
      bti_pkg::ST_FINAL: begin
        state_next = bti_pkg::ST_DONE;
      end
      bti_pkg::ST_DONE: begin
        out_load = !out_valid || out_ch.ready;
        if (out_load) begin
          state_next = bti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bti_pkg::ST_IDLE;
      end
    endcase
  end

  // Shared add/subtract unit operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      bti_pkg::ST_MUL: begin
        alu_a = {2'b00, p_hi};
        alu_b = {2'b00, dy};
      end
      bti_pkg::ST_OVF: begin
        alu_a   = {2'b00, p_hi};
        alu_b   = {2'b00, dx};
        alu_sub = 1'b1;
      end
      bti_pkg::ST_DIV: begin
        alu_a   = {1'b0, rem2};
        alu_b   = {2'b00, dx};
        alu_sub = 1'b1;
      end
      bti_pkg::ST_FINAL: begin
        alu_a   = {{2{prev_y[W-1]}}, prev_y};
        alu_b   = {2'b00, p_lo};
        alu_sub = neg_div;
      end
      default: ;
    endcase
    alu_sum = alu_sub ? alu_a - alu_b : alu_a + alu_b;
  end

  assign rem2    = {p_hi, p_lo[W-1]};
  assign div_ge  = !alu_sum[W+1];
  assign mul_sum = p_lo[0] ? alu_sum[W:0] : {1'b0, p_hi};

  // Saturate y0 +/- quotient to the signed range
  always_comb begin
    if ($signed(alu_sum) > $signed({2'b00, sat_max})) begin
      final_y = sat_max;
    end else if ($signed(alu_sum) < $signed({2'b11, sat_min})) begin
      final_y = sat_min;
    end else begin
      final_y = alu_sum[W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bti_pkg::ST_IDLE;
      table_length <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        table_length <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= in_ch.entry_x;
      y_mem[wr_addr] <= in_ch.entry_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      bti_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          q     <= in_ch.query_x;
          last  <= n_m1[AW-1:0];
          res_y <= '0;
          if (in_ch.command == bti_pkg::CMD_WRITE) begin
            res_status <= idx_ok ? bti_pkg::STATUS_OK : bti_pkg::STATUS_RANGE;
          end else begin
            res_status <= bti_pkg::STATUS_EMPTY;
          end
        end
      end
      bti_pkg::ST_FETCH_LAST: begin
        // first entry on the read port
        if (q >= rd_x) begin
          res_y      <= rd_y;
          res_status <= bti_pkg::STATUS_OK;
        end
        prev_x <= rd_x;
        prev_y <= rd_y;
      end
      bti_pkg::ST_CHECK_LAST: begin
        if (q <= rd_x) begin
          res_y      <= rd_y;
          res_status <= bti_pkg::STATUS_OK;
        end
        cnt <= AW'(1);
      end
      bti_pkg::ST_SCAN: begin
        if (seg_hit || cnt == last) begin
          cur_x <= rd_x;
          cur_y <= rd_y;
        end else begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          cnt    <= cnt + AW'(1);
        end
      end
      bti_pkg::ST_DIFF: begin
        dy      <= abs_diff(cur_y, prev_y);
        dq      <= abs_diff(q, prev_x);
        dx      <= abs_diff(cur_x, prev_x);
        neg_num <= (cur_y < prev_y) != (q < prev_x);
        neg_div <= ((cur_y < prev_y) != (q < prev_x)) != (cur_x < prev_x);
      end
      bti_pkg::ST_SETUP: begin
        p_hi <= '0;
        p_lo <= dq;
        step <= '0;
        // zero denominator: infinite quotient unless the numerator is zero
        res_status <= (dx == '0) ? bti_pkg::STATUS_ZERO_DEN : bti_pkg::STATUS_OK;
        if (dy == '0 || dq == '0) begin
          res_y <= prev_y;
        end else begin
          res_y <= neg_num ? sat_min : sat_max;
        end
      end
      bti_pkg::ST_MUL: begin
        p_hi <= mul_sum[W:1];
        p_lo <= {mul_sum[0], p_lo[W-1:1]};
        step <= step + SW'(1);
      end
      bti_pkg::ST_OVF: begin
        step       <= '0;
        res_y      <= neg_div ? sat_min : sat_max;
        res_status <= bti_pkg::STATUS_OK;
      end
      bti_pkg::ST_DIV: begin
        p_hi <= div_ge ? alu_sum[W-1:0] : rem2[W-1:0];
        p_lo <= {p_lo[W-2:0], div_ge};
        step <= step + SW'(1);
      end
      bti_pkg::ST_FINAL: begin
        res_y      <= final_y;
        res_status <= bti_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= res_y;
      out_status <= res_status;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.result_y = out_result;
  assign out_ch.status   = out_status;

`ifndef SYNTHESIS
  // Scan pointer stays inside the table in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == bti_pkg::ST_SCAN |-> (cnt <= last) && (cnt != '0))
    else $error("scan pointer outside table");

  // Partial remainder always below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == bti_pkg::ST_DIV |-> p_hi < dx)
    else $error("divider remainder not below divisor");

  // Zero denominator ends the query with its status
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (state == bti_pkg::ST_SETUP) && (dx == '0) |=>
      (state == bti_pkg::ST_DONE) && (res_status == bti_pkg::STATUS_ZERO_DEN))
    else $error("zero denominator not reported");

  // Query on an empty table answers at once with zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ready && (in_ch.command == bti_pkg::CMD_QUERY) && (n_ext == '0) |=>
      (state == bti_pkg::ST_DONE) && (res_status == bti_pkg::STATUS_EMPTY) && (res_y == '0))
    else $error("empty table query mishandled");

  // Write beyond the length is refused
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ready && (in_ch.command == bti_pkg::CMD_WRITE) && !idx_ok |->
      !wr_en ##1 (res_status == bti_pkg::STATUS_RANGE))
    else $error("out of range write not refused");
`endif

endmodule

@@ verif/bti_checker.sv @@
// Watches both channels and the length register, predicts each result in item order
// and compares it field by field with what the block returns.
module bti_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bti_pkg::LEN_W-1:0] cfg_wr_data,
  bti_in_if                         in_ch,
  bti_out_if                        out_ch,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW    = 32;
  localparam int DEPTH = 64;
  localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;

  typedef logic signed [VW-1:0] value_t;
  typedef struct packed {
    value_t           y;
    bti_pkg::status_t status;
  } lookup_t;

  value_t                    bp_x [DEPTH];
  value_t                    bp_y [DEPTH];
  logic [bti_pkg::LEN_W-1:0] length_reg;
  lookup_t                   expected_q [$];

  // Segment search and interpolation, n is at least 1
  function automatic lookup_t interpolate_at(value_t q, int n);
    lookup_t             r;
    int                  seg;
    logic signed [127:0] x0, x1, y0, y1, qw, num, den, sum;
    r.status = bti_pkg::STATUS_OK;
    // at or beyond either end of the table
    if (q >= bp_x[0]) begin
      r.y = bp_y[0];
      return r;
    end
    if (q <= bp_x[n-1]) begin
      r.y = bp_y[n-1];
      return r;
    end
    // first bracketing segment wins; the last segment if none brackets q
    seg = n - 2;
    for (int k = n - 2; k >= 0; k--) begin
      if (q < bp_x[k] && q >= bp_x[k+1]) seg = k;
    end
    x0  = bp_x[seg];
    x1  = bp_x[seg+1];
    y0  = bp_y[seg];
    y1  = bp_y[seg+1];
    qw  = q;
    num = (y1 - y0) * (qw - x0);
    den = x1 - x0;
    if (den == 0) begin
      // flat segment: slope is infinite with the sign of the numerator
      r.status = bti_pkg::STATUS_ZERO_DEN;
      if (num == 0) sum = y0;
      else if (num < 0) sum = WIDE_MIN;
      else sum = WIDE_MAX;
    end else begin
      sum = y0 + num / den;  // signed divide truncates toward zero
    end
    if (sum > WIDE_MAX) sum = WIDE_MAX;
    else if (sum < WIDE_MIN) sum = WIDE_MIN;
    r.y = sum[VW-1:0];
    return r;
  endfunction

  // One item: update the table copy or look up, and give the expected result
  function automatic lookup_t apply_item(logic cmd, logic [bti_pkg::IDX_W-1:0] idx,
                                         value_t ex, value_t ey, value_t q);
    lookup_t r;
    int      n;
    n = (length_reg > DEPTH) ? DEPTH : int'(length_reg);
    r.y      = '0;
    r.status = bti_pkg::STATUS_OK;
    if (cmd == bti_pkg::CMD_WRITE) begin
      if (idx >= n) begin
        r.status = bti_pkg::STATUS_RANGE;
      end else begin
        bp_x[idx] = ex;
        bp_y[idx] = ey;
      end
    end else if (n == 0) begin
      r.status = bti_pkg::STATUS_EMPTY;
    end else begin
      r = interpolate_at(q, n);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // Results leave in item order; retire before taking the item of this edge
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      length_reg = '0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) length_reg = cfg_wr_data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item outstanding", out_ch.result_y, 'x);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.result_y !== want.y)
            report_mismatch("result_y", out_ch.result_y, want.y);
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.insert(expected_q.size(),
                          apply_item(in_ch.command, in_ch.entry_index, in_ch.entry_x,
                                     in_ch.entry_y, in_ch.query_x));
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 160;
  localparam int PHASE_ITEMS = 55;
  localparam int MAX_PAIRS   = 64;

  typedef logic signed [31:0]        value_t;
  typedef logic [bti_pkg::IDX_W-1:0] index_t;
  typedef logic [bti_pkg::LEN_W-1:0] length_t;

  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t ONE     = 32'sh0001_0000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  length_t          cfg_wr_data;
  int               fail_count;
  int               outstanding;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               cycle_count;
  int               pairs_used;
  value_t           table_x [MAX_PAIRS];  // x column as written, to aim queries

  bti_in_if  in_ch ();
  bti_out_if out_ch ();

  breakpoint_table_interpolation i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  bti_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Present one item after random idle cycles, hold until accepted
  task automatic send_item(input logic cmd, input index_t idx,
                           input value_t ex, input value_t ey, input value_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.entry_index <= idx;
    in_ch.entry_x     <= ex;
    in_ch.entry_y     <= ey;
    in_ch.query_x     <= q;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_pair(input index_t idx, input value_t ex, input value_t ey);
    if (idx < pairs_used) table_x[idx] = ex;
    send_item(bti_pkg::CMD_WRITE, idx, ex, ey, $urandom);
  endtask

  task automatic query(input value_t q);
    send_item(bti_pkg::CMD_QUERY, index_t'($urandom_range(63)), $urandom, $urandom, q);
  endtask

  // Sender stops until every outstanding result is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_length(input length_t len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pairs_used = (len > MAX_PAIRS) ? MAX_PAIRS : int'(len);
  endtask

  // Load every pair in use with x in decreasing order
  task automatic fill_table(input int mode);
    value_t xs [MAX_PAIRS];
    value_t v;
    int     j;
    for (int k = 0; k < pairs_used; k++) begin
      case (mode)
        0:       v = $urandom;
        1:       v = $urandom_range(2000 << 16) - (1000 << 16);
        default: v = $urandom_range(7) << 16;  // many equal x
      endcase
      j = k;
      while (j > 0 && xs[j-1] < v) begin
        xs[j] = xs[j-1];
        j--;
      end
      xs[j] = v;
    end
    for (int k = 0; k < pairs_used; k++) write_pair(index_t'(k), xs[k], $urandom);
  endtask

  // Query x: ends, breakpoints and their neighbours, inside the span, or anything
  function automatic value_t pick_query();
    longint      lo, hi;
    int          k;
    int unsigned roll;
    roll = $urandom_range(99);
    if (pairs_used == 0 || roll < 20) return $urandom;
    k  = $urandom_range(pairs_used - 1);
    lo = table_x[pairs_used-1];
    hi = table_x[0];
    if (roll < 30) return roll[0] ? VAL_MAX : VAL_MIN;
    if (roll < 50) return table_x[k];
    if (roll < 60) return table_x[k] + (roll[1] ? 1 : -1);
    if (hi <= lo) return $urandom;
    return value_t'(lo + longint'($urandom) % (hi - lo + 1));
  endfunction

  initial begin
    int phase_len [10];
    int len;
    phase_len = '{64, 1, 2, 127, 0, 65, 0, 3, 64, 0};
    in_ch.valid       <= 1'b0;
    in_ch.command     <= bti_pkg::CMD_WRITE;
    in_ch.entry_index <= '0;
    in_ch.entry_x     <= '0;
    in_ch.entry_y     <= '0;
    in_ch.query_x     <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    send_idle_pct  = 11;
    recv_stall_pct = 77;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, writes beyond the length
    query($urandom);
    write_pair(0, VAL_MAX, VAL_MAX);
    write_pair(63, VAL_MIN, VAL_MAX);
    // one pair: every query lands on it
    set_length(1);
    write_pair(0, 0, VAL_MAX);
    write_pair(1, ONE, ONE);
    query(0);
    query(VAL_MIN);
    // four pairs spanning the whole range with extreme y
    set_length(4);
    write_pair(0, VAL_MAX, VAL_MIN);
    write_pair(1, ONE, VAL_MAX);
    write_pair(2, -ONE, VAL_MIN);
    write_pair(3, VAL_MIN, 0);
    query(VAL_MAX);
    query(VAL_MIN);
    query(0);
    query(ONE);
    query(VAL_MAX - 1);
    query(VAL_MIN + 1);
    query(5);
    // table no longer decreasing
    write_pair(2, 5 * ONE, 12345);
    query(3 * ONE);
    write_pair(4, ONE, ONE);

    // Random phases over several table lengths
    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_idle_pct  = 77;
        recv_stall_pct = 11;
      end
      if (p == 7) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      len = (p == 6 || p == 9) ? $urandom_range(4, 63) : phase_len[p];
      set_length(length_t'(len));
      fill_table(p % 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 15)
          write_pair(index_t'($urandom_range(63)), $urandom, $urandom);
        else query(pick_query());
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bti_pkg.sv
rtl/bti_if.sv
rtl/breakpoint_table_interpolation.sv
verif/bti_checker.sv
verif/testbench.sv
